/* sv/stgrad_pkg.sv */
// Shared constants and types of the spatiotemporal gradient unit.
`default_nettype none

package stgrad_pkg;

  // Default sizing of the line buffer and of a pixel.
  localparam int MAX_COLS_DEF   = 2048;
  localparam int PIXEL_BITS_DEF = 8;

  // Fixed widths of the configuration and result fields.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 12;
  localparam int GRAD_W     = 11;
  localparam int COORD_W    = 11;

  // Largest number of rows per frame.
  localparam int ROW_LIMIT = 2048;

  // Reset values of the configuration registers.
  localparam logic [CFG_DATA_W-1:0] FRAME_COLS_RST = 12'd640;
  localparam logic [CFG_DATA_W-1:0] FRAME_ROWS_RST = 12'd480;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd1;

  // Kinds of result one pixel can cause, in raster order of emission.
  typedef enum logic [1:0] {
    KIND_INTERIOR = 2'd0,
    KIND_LAST_COL = 2'd1,
    KIND_LAST_ROW = 2'd2,
    KIND_CORNER   = 2'd3
  } res_kind_e;

endpackage

`default_nettype wire

/* sv/spatiotemporal_gradient_2x2x2_unit.sv */
// Horn-Schunck spatiotemporal gradient unit over a 2x2x2 pixel cube.
// Flow: a pixel is held in the item stage register, and each result it causes is loaded into
// the output register when that register is free; further results of that pixel follow.
// Throughput: one pixel pair per cycle while the result port is not stalled; a pixel in the last
// column or last row causes up to four results, which the single result port takes one at a time.
// Reset: asynchronous, active low; counters return to row 0, column 0 and the
// registers to 640 columns by 480 rows. The line buffer is not cleared: row 0 fills it.
`default_nettype none

module spatiotemporal_gradient_2x2x2_unit #(
  parameter int MAX_COLS   = stgrad_pkg::MAX_COLS_DEF,
  parameter int PIXEL_BITS = stgrad_pkg::PIXEL_BITS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration write channel
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [stgrad_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [stgrad_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // Pixel input channel
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic [PIXEL_BITS-1:0]               pix_first_i,
  input  wire logic [PIXEL_BITS-1:0]               pix_second_i,
  // Result channel
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [stgrad_pkg::GRAD_W-1:0]     grad_x_o,
  output logic signed [stgrad_pkg::GRAD_W-1:0]     grad_y_o,
  output logic signed [stgrad_pkg::GRAD_W-1:0]     grad_t_o,
  output logic [stgrad_pkg::COORD_W-1:0]           out_row_o,
  output logic [stgrad_pkg::COORD_W-1:0]           out_col_o,
  output logic                                     frame_done_o
);

  localparam int PB   = PIXEL_BITS;
  localparam int CW   = (MAX_COLS > 2) ? $clog2(MAX_COLS) : 1;
  localparam int CNTW = $clog2(MAX_COLS + 1);
  localparam int CLW  = (CNTW > stgrad_pkg::CFG_DATA_W) ? CNTW : stgrad_pkg::CFG_DATA_W;
  localparam int SW   = (PB + 3 > 12) ? PB + 3 : 12;
  localparam int RW   = stgrad_pkg::COORD_W;
  localparam int GW   = stgrad_pkg::GRAD_W;

  localparam logic signed [SW-1:0] SAT_HI = SW'(1023);
  localparam logic signed [SW-1:0] SAT_LO = -(SW'(1024));

  // Saturate a gradient sum to the result width.
  function automatic logic signed [GW-1:0] sat_grad(input logic signed [SW-1:0] v);
    logic signed [SW-1:0] c;
    c = v;
    if (v > SAT_HI) begin
      c = SAT_HI;
    end else if (v < SAT_LO) begin
      c = SAT_LO;
    end
    return c[GW-1:0];
  endfunction

  // Configuration registers
  logic [stgrad_pkg::CFG_DATA_W-1:0] frame_cols_q, frame_rows_q;

  // Raster counters
  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;

  // Item stage: pixel, line buffer read data and pending results
  logic          s1_valid_q;
  logic [3:0]    s1_mask_q;
  logic [PB-1:0] s1_a_q, s1_b_q;
  logic [CW-1:0] s1_col_q;
  logic [RW-1:0] s1_row_q;
  logic [2*PB-1:0] rd_q;

  // Previous pixel of the row and the pixel above it
  logic [PB-1:0] prev_a_q, prev_b_q, prev_ua_q, prev_ub_q;

  // Line buffer holding both frames of the previous row
  logic [2*PB-1:0] line_mem [MAX_COLS];

  logic out_valid_q;

  logic [CLW-1:0] cols_ext, cols_eff;
  logic [stgrad_pkg::CFG_DATA_W-1:0] rows_eff;
  logic [CW-1:0] last_col;
  logic [RW-1:0] last_row;
  logic [31:0]   last_col_ext;
  logic [RW-1:0] last_col_11;

  logic in_fire, cfg_fire, out_load, emit_fire, s1_retire;
  logic at_last_col, at_last_row;
  logic [3:0] mask_d, low_bit, mask_after;
  stgrad_pkg::res_kind_e kind;

  logic [PB-1:0] ua, ub;
  logic [PB-1:0] a0, a1, a2, a3, b0, b1, b2, b3;
  logic [RW-1:0] res_row;
  logic [CW-1:0] res_col;
  logic [31:0]   res_col_ext;
  logic signed [SW-1:0] gx_s, gy_s, gt_s;

  // Effective frame size, clamped to the supported range.
  always_comb begin
    cols_ext = CLW'(frame_cols_q);
    if (cols_ext < CLW'(2)) begin
      cols_eff = CLW'(2);
    end else if (cols_ext > CLW'(MAX_COLS)) begin
      cols_eff = CLW'(MAX_COLS);
    end else begin
      cols_eff = cols_ext;
    end
    if (frame_rows_q < 12'd2) begin
      rows_eff = 12'd2;
    end else if (frame_rows_q > 12'(stgrad_pkg::ROW_LIMIT)) begin
      rows_eff = 12'(stgrad_pkg::ROW_LIMIT);
    end else begin
      rows_eff = frame_rows_q;
    end
    last_col     = CW'(cols_eff - CLW'(1));
    last_row     = RW'(rows_eff - 12'd1);
    last_col_ext = 32'(last_col);
    last_col_11  = last_col_ext[RW-1:0];
  end

  // Handshakes and the results this pixel will cause.
  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i && cfg_ready_o;
  assign out_load    = !out_valid_q || out_ready_i;
  assign emit_fire   = s1_valid_q && (s1_mask_q != 4'd0) && out_load;
  assign low_bit     = s1_mask_q & (~s1_mask_q + 4'd1);
  assign mask_after  = s1_mask_q & ~low_bit;
  assign s1_retire   = s1_valid_q && ((s1_mask_q == 4'd0) || (emit_fire && mask_after == 4'd0));
  assign in_ready_o  = !s1_valid_q || s1_retire;
  assign in_fire     = in_valid_i && in_ready_o;

  assign at_last_col = (col_q == last_col);
  assign at_last_row = (row_q == last_row);
  assign mask_d = {at_last_row && at_last_col,
                   at_last_row && (col_q != '0),
                   (row_q != '0) && at_last_col,
                   (row_q != '0) && (col_q != '0)};

  // Configuration registers and raster counters.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_cols_q <= stgrad_pkg::FRAME_COLS_RST;
      frame_rows_q <= stgrad_pkg::FRAME_ROWS_RST;
      col_q        <= '0;
      row_q        <= '0;
    end else if (cfg_fire) begin
      case (cfg_index_i)
        stgrad_pkg::REG_FRAME_COLS: begin
          frame_cols_q <= cfg_data_i;
          col_q        <= '0;
          row_q        <= '0;
        end
        stgrad_pkg::REG_FRAME_ROWS: begin
          frame_rows_q <= cfg_data_i;
          col_q        <= '0;
          row_q        <= '0;
        end
        default: ;
      endcase
    end else if (in_fire) begin
      if (at_last_col) begin
        col_q <= '0;
        row_q <= at_last_row ? '0 : row_q + RW'(1);
      end else begin
        col_q <= col_q + CW'(1);
      end
    end
  end

  // Line buffer: the read returns the row above before this pixel replaces it.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      line_mem[col_q] <= {pix_first_i, pix_second_i};
      rd_q            <= line_mem[col_q];
    end
  end

  // Item stage control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_mask_q  <= 4'd0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
      s1_mask_q  <= mask_d;
    end else if (s1_retire) begin
      s1_valid_q <= 1'b0;
      s1_mask_q  <= 4'd0;
    end else if (emit_fire) begin
      s1_mask_q  <= mask_after;
    end
  end

  // Item stage payload.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_a_q   <= pix_first_i;
      s1_b_q   <= pix_second_i;
      s1_col_q <= col_q;
      s1_row_q <= row_q;
    end
  end

  // Neighbors left and upper left, updated as each pixel leaves the item stage.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_a_q  <= '0;
      prev_b_q  <= '0;
      prev_ua_q <= '0;
      prev_ub_q <= '0;
    end else if (s1_retire) begin
      prev_a_q  <= s1_a_q;
      prev_b_q  <= s1_b_q;
      prev_ua_q <= ua;
      prev_ub_q <= ub;
    end
  end

  assign ua = rd_q[2*PB-1:PB];
  assign ub = rd_q[PB-1:0];

  // Pick the next pending result and build its cube.
  always_comb begin
    if (s1_mask_q[0]) begin
      kind = stgrad_pkg::KIND_INTERIOR;
    end else if (s1_mask_q[1]) begin
      kind = stgrad_pkg::KIND_LAST_COL;
    end else if (s1_mask_q[2]) begin
      kind = stgrad_pkg::KIND_LAST_ROW;
    end else begin
      kind = stgrad_pkg::KIND_CORNER;
    end

    case (kind)
      stgrad_pkg::KIND_INTERIOR: begin
        a0 = prev_ua_q; a1 = ua;     a2 = prev_a_q; a3 = s1_a_q;
        b0 = prev_ub_q; b1 = ub;     b2 = prev_b_q; b3 = s1_b_q;
        res_row = s1_row_q - RW'(1);
        res_col = s1_col_q - CW'(1);
      end
      stgrad_pkg::KIND_LAST_COL: begin
        a0 = ua;        a1 = ua;     a2 = s1_a_q;   a3 = s1_a_q;
        b0 = ub;        b1 = ub;     b2 = s1_b_q;   b3 = s1_b_q;
        res_row = s1_row_q - RW'(1);
        res_col = s1_col_q;
      end
      stgrad_pkg::KIND_LAST_ROW: begin
        a0 = prev_a_q;  a1 = s1_a_q; a2 = prev_a_q; a3 = s1_a_q;
        b0 = prev_b_q;  b1 = s1_b_q; b2 = prev_b_q; b3 = s1_b_q;
        res_row = s1_row_q;
        res_col = s1_col_q - CW'(1);
      end
      default: begin
        a0 = s1_a_q;    a1 = s1_a_q; a2 = s1_a_q;   a3 = s1_a_q;
        b0 = s1_b_q;    b1 = s1_b_q; b2 = s1_b_q;   b3 = s1_b_q;
        res_row = s1_row_q;
        res_col = s1_col_q;
      end
    endcase
    res_col_ext = 32'(res_col);
  end

  // Four times the derivatives as plain sums over the cube.
  always_comb begin
    gx_s = (SW'(a1) + SW'(a3) + SW'(b1) + SW'(b3)) - (SW'(a0) + SW'(a2) + SW'(b0) + SW'(b2));
    gy_s = (SW'(a2) + SW'(a3) + SW'(b2) + SW'(b3)) - (SW'(a0) + SW'(a1) + SW'(b0) + SW'(b1));
    gt_s = (SW'(b0) + SW'(b1) + SW'(b2) + SW'(b3)) - (SW'(a0) + SW'(a1) + SW'(a2) + SW'(a3));
  end

  // Result register control.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result register payload.
  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      grad_x_o     <= sat_grad(gx_s);
      grad_y_o     <= sat_grad(gy_s);
      grad_t_o     <= sat_grad(gt_s);
      out_row_o    <= res_row;
      out_col_o    <= res_col_ext[RW-1:0];
      frame_done_o <= (kind == stgrad_pkg::KIND_CORNER);
    end
  end

  assign out_valid_o = out_valid_q;

  // The final result of a frame is the flat corner cube.
  a_done_corner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && frame_done_o |->
      grad_x_o == '0 && grad_y_o == '0 && out_row_o == last_row && out_col_o == last_col_11)
    else $error("frame_done on a result that is not the last pixel of the frame");

  // A pixel with several pending results holds off the next pixel.
  a_hold_multi: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && $countones(s1_mask_q) > 1 |-> !in_ready_o)
    else $error("input taken while several results are still pending");

  // Results never name a row or column outside the frame.
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_col_o <= last_col_11 && out_row_o <= last_row)
    else $error("result coordinates outside the frame");

endmodule

`default_nettype wire

/* tb/spatiotemporal_gradient_2x2x2_unit_tb.sv */
// Self-checking testbench of the spatiotemporal gradient unit with its own gradient predictor.
module spatiotemporal_gradient_2x2x2_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int PIX_W       = stgrad_pkg::PIXEL_BITS_DEF;
  localparam int LINE_DEPTH  = stgrad_pkg::MAX_COLS_DEF;
  localparam int PIX_MAX     = (1 << PIX_W) - 1;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYC  = 8;
  localparam int RANDOM_GOAL = 180;

  // Pixel styles used by the random stimulus.
  typedef enum int {
    STYLE_UNIFORM,
    STYLE_EXTREME,
    STYLE_SMOOTH
  } pix_style_e;

  typedef struct packed {
    logic [PIX_W-1:0] first;
    logic [PIX_W-1:0] second;
  } pix_pair_t;

  typedef struct packed {
    logic signed [stgrad_pkg::GRAD_W-1:0] gx;
    logic signed [stgrad_pkg::GRAD_W-1:0] gy;
    logic signed [stgrad_pkg::GRAD_W-1:0] gt;
    logic [stgrad_pkg::COORD_W-1:0]       row;
    logic [stgrad_pkg::COORD_W-1:0]       col;
    logic                                 done;
  } grad_word_t;

  logic                                 clk_i;
  logic                                 rst_ni;
  logic                                 cfg_valid_i  = 1'b0;
  logic                                 cfg_ready_o;
  logic [stgrad_pkg::CFG_IDX_W-1:0]     cfg_index_i  = stgrad_pkg::REG_FRAME_COLS;
  logic [stgrad_pkg::CFG_DATA_W-1:0]    cfg_data_i   = '0;
  logic                                 in_valid_i   = 1'b0;
  logic                                 in_ready_o;
  logic [PIX_W-1:0]                     pix_first_i  = '0;
  logic [PIX_W-1:0]                     pix_second_i = '0;
  logic                                 out_valid_o;
  logic                                 out_ready_i  = 1'b0;
  logic signed [stgrad_pkg::GRAD_W-1:0] grad_x_o;
  logic signed [stgrad_pkg::GRAD_W-1:0] grad_y_o;
  logic signed [stgrad_pkg::GRAD_W-1:0] grad_t_o;
  logic [stgrad_pkg::COORD_W-1:0]       out_row_o;
  logic [stgrad_pkg::COORD_W-1:0]       out_col_o;
  logic                                 frame_done_o;

  spatiotemporal_gradient_2x2x2_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .pix_first_i  (pix_first_i),
    .pix_second_i (pix_second_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .grad_x_o     (grad_x_o),
    .grad_y_o     (grad_y_o),
    .grad_t_o     (grad_t_o),
    .out_row_o    (out_row_o),
    .out_col_o    (out_col_o),
    .frame_done_o (frame_done_o)
  );

  // Stimulus and scoreboard storage.
  pix_pair_t  pixel_q[$];
  grad_word_t grad_expect_q[$];
  int         fail_count  = 0;
  int         cycle_count = 0;
  bit         in_fire_q   = 1'b0;

  // Predictor state: frame geometry, line stores and the cube neighbors.
  logic [stgrad_pkg::CFG_DATA_W-1:0] frame_cols_q = stgrad_pkg::FRAME_COLS_RST;
  logic [stgrad_pkg::CFG_DATA_W-1:0] frame_rows_q = stgrad_pkg::FRAME_ROWS_RST;
  int unsigned above_first [LINE_DEPTH];
  int unsigned above_second[LINE_DEPTH];
  int unsigned left_first_q   = 0;
  int unsigned left_second_q  = 0;
  int unsigned diag_first_q   = 0;
  int unsigned diag_second_q  = 0;
  int unsigned col_pos        = 0;
  int unsigned row_pos        = 0;

  // Sender and receiver pacing state.
  int        burst_left  = 0;
  int        gap_left    = 0;
  int        stall_mode  = 0;
  int        mode_left   = 0;
  int        stall_left  = 0;
  pix_pair_t next_pair;
  grad_word_t oldest_word;

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // A frame dimension register as the block uses it.
  function automatic int clamp_dim(int unsigned v, int unsigned hi);
    if (v < 2) return 2;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic signed [stgrad_pkg::GRAD_W-1:0] sat_grad(int v);
    if (v > 1023) v = 1023;
    if (v < -1024) v = -1024;
    return v[stgrad_pkg::GRAD_W-1:0];
  endfunction

  // Derivatives over one 2x2x2 cube; index 0 top-left, 1 top-right,
  // 2 bottom-left, 3 bottom-right, a from the first frame, b from the second.
  function automatic grad_word_t cube_grad(int row, int col,
                                           int a0, int a1, int a2, int a3,
                                           int b0, int b1, int b2, int b3);
    grad_word_t w;
    w.gx   = sat_grad((a1 - a0) + (a3 - a2) + (b1 - b0) + (b3 - b2));
    w.gy   = sat_grad((a2 - a0) + (a3 - a1) + (b2 - b0) + (b3 - b1));
    w.gt   = sat_grad((b0 - a0) + (b1 - a1) + (b2 - a2) + (b3 - a3));
    w.row  = row[stgrad_pkg::COORD_W-1:0];
    w.col  = col[stgrad_pkg::COORD_W-1:0];
    w.done = 1'b0;
    return w;
  endfunction

  // Advance the predictor by one accepted pixel pair and queue its results.
  function automatic void predict_pixel(int unsigned ca, int unsigned cb);
    int unsigned cols, rows, c, r, ua, ub;
    grad_word_t  words[$];
    cols = clamp_dim(frame_cols_q, LINE_DEPTH);
    rows = clamp_dim(frame_rows_q, stgrad_pkg::ROW_LIMIT);
    if (col_pos >= cols) col_pos = 0;
    if (row_pos >= rows) row_pos = 0;
    c  = col_pos;
    r  = row_pos;
    ua = above_first[c];
    ub = above_second[c];

    // Results leave in raster order: interior, last column, last row, corner.
    if (r >= 1 && c >= 1)
      words.push_back(cube_grad(r - 1, c - 1, diag_first_q, ua, left_first_q, ca,
                                diag_second_q, ub, left_second_q, cb));
    if (r >= 1 && c == cols - 1)
      words.push_back(cube_grad(r - 1, c, ua, ua, ca, ca, ub, ub, cb, cb));
    if (r == rows - 1 && c >= 1)
      words.push_back(cube_grad(r, c - 1, left_first_q, ca, left_first_q, ca,
                                left_second_q, cb, left_second_q, cb));
    if (r == rows - 1 && c == cols - 1)
      words.push_back(cube_grad(r, c, ca, ca, ca, ca, cb, cb, cb, cb));

    above_first[c]  = ca;
    above_second[c] = cb;
    diag_first_q    = ua;
    diag_second_q   = ub;
    left_first_q    = ca;
    left_second_q   = cb;

    // Step the raster position; the frame's last word carries the done flag.
    if (c + 1 >= cols) begin
      col_pos = 0;
      if (r + 1 >= rows) begin
        row_pos = 0;
        if (words.size() > 0) words[words.size() - 1].done = 1'b1;
      end else begin
        row_pos = r + 1;
      end
    end else begin
      col_pos = c + 1;
    end
    foreach (words[i]) grad_expect_q.push_back(words[i]);
  endfunction

  function automatic void check_field(string name, int exp_v, int act_v);
    if (exp_v != act_v) begin
      $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endfunction

  // Monitor: predict on accepted pixels, check accepted result words.
  always @(posedge clk_i) begin
    in_fire_q = rst_ni && in_valid_i && in_ready_o;
    if (in_fire_q) predict_pixel(pix_first_i, pix_second_i);
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (grad_expect_q.size() == 0) begin
        $error("unexpected result word at row %0d col %0d", out_row_o, out_col_o);
        fail_count++;
      end else begin
        oldest_word = grad_expect_q.pop_front();
        check_field("grad_x", int'(oldest_word.gx), int'(grad_x_o));
        check_field("grad_y", int'(oldest_word.gy), int'(grad_y_o));
        check_field("grad_t", int'(oldest_word.gt), int'(grad_t_o));
        check_field("out_row", int'(oldest_word.row), int'(out_row_o));
        check_field("out_col", int'(oldest_word.col), int'(out_col_o));
        check_field("frame_done", int'(oldest_word.done), int'(frame_done_o));
      end
    end
  end

  // Run limit.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Pixel driver: bursts of random length separated by random gaps.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (!in_valid_i || in_fire_q) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pixel_q.size() != 0) begin
        next_pair = pixel_q.pop_front();
        pix_first_i  <= next_pair.first;
        pix_second_i <= next_pair.second;
        in_valid_i   <= 1'b1;
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
          gap_left   = $urandom_range(0, 5);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Result receiver: changes its stall pattern every so often.
  always @(negedge clk_i) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 3);
      mode_left  = $urandom_range(32, 200);
    end else begin
      mode_left--;
    end
    case (stall_mode)
      0: begin
        out_ready_i <= 1'b1;
      end
      1: begin
        out_ready_i <= ($urandom_range(0, 9) >= 3);
      end
      2: begin
        out_ready_i <= ((cycle_count % 4) != 3);
      end
      default: begin
        if (stall_left == 0 && $urandom_range(0, 7) == 0) stall_left = $urandom_range(2, 8);
        if (stall_left > 0) begin
          stall_left--;
          out_ready_i <= 1'b0;
        end else begin
          out_ready_i <= 1'b1;
        end
      end
    endcase
  end

  // Wait until every queued pixel is taken and every expected word has come,
  // then give the pipeline time to empty.
  task automatic settle_block();
    while (pixel_q.size() != 0 || in_valid_i || grad_expect_q.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  // One register write; the frame restarts at row 0, column 0.
  task automatic write_frame_reg(logic [stgrad_pkg::CFG_IDX_W-1:0] idx,
                                 logic [stgrad_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == stgrad_pkg::REG_FRAME_COLS) frame_cols_q = val;
    else frame_rows_q = val;
    col_pos = 0;
    row_pos = 0;
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic push_pair(int unsigned pa, int unsigned pb);
    pix_pair_t p;
    p.first  = pa[PIX_W-1:0];
    p.second = pb[PIX_W-1:0];
    pixel_q.push_back(p);
  endtask

  // Queue random pixel pairs of the given style.
  task automatic push_random(int count, pix_style_e style);
    int unsigned pa, pb;
    repeat (count) begin
      case (style)
        STYLE_EXTREME: begin
          pa = $urandom_range(0, 1) * PIX_MAX;
          pb = $urandom_range(0, 1) * PIX_MAX;
        end
        STYLE_SMOOTH: begin
          pa = $urandom_range(0, PIX_MAX);
          pb = pa + $urandom_range(0, 14);
          pb = (pb < 7) ? 0 : pb - 7;
          if (pb > PIX_MAX) pb = PIX_MAX;
        end
        default: begin
          pa = $urandom_range(0, PIX_MAX);
          pb = $urandom_range(0, PIX_MAX);
        end
      endcase
      push_pair(pa, pb);
    end
  endtask

  // Main sequence.
  initial begin
    int random_items;
    int frame_px;
    int count;
    int unsigned cols_val, rows_val, wmask;
    random_items = 0;
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Default geometry: the start of row 0, which gives no results.
    push_random(24, STYLE_UNIFORM);
    settle_block();

    // Smallest frame, set through out-of-range low values; each frame drives
    // one derivative to its positive or negative extreme.
    write_frame_reg(stgrad_pkg::REG_FRAME_COLS, 12'd0);
    write_frame_reg(stgrad_pkg::REG_FRAME_ROWS, 12'd1);
    push_pair(0, 0);
    push_pair(PIX_MAX, PIX_MAX);
    // The sender holds off mid-frame until everything has come back.
    settle_block();
    push_pair(0, 0);
    push_pair(PIX_MAX, PIX_MAX);
    push_pair(PIX_MAX, PIX_MAX); push_pair(0, 0);
    push_pair(PIX_MAX, PIX_MAX); push_pair(0, 0);
    push_pair(0, 0); push_pair(0, 0);
    push_pair(PIX_MAX, PIX_MAX); push_pair(PIX_MAX, PIX_MAX);
    push_pair(PIX_MAX, PIX_MAX); push_pair(PIX_MAX, PIX_MAX);
    push_pair(0, 0); push_pair(0, 0);
    repeat (4) push_pair(0, PIX_MAX);
    repeat (4) push_pair(PIX_MAX, 0);
    settle_block();

    // Widest frame, column register above the line buffer size: a run of row 0.
    write_frame_reg(stgrad_pkg::REG_FRAME_ROWS, 12'd0);
    write_frame_reg(stgrad_pkg::REG_FRAME_COLS, 12'hFFF);
    push_random(24, STYLE_SMOOTH);
    settle_block();

    // Tallest frame, row register at its top value: the first twenty rows.
    write_frame_reg(stgrad_pkg::REG_FRAME_COLS, 12'd2);
    write_frame_reg(stgrad_pkg::REG_FRAME_ROWS, 12'hFFF);
    push_random(40, STYLE_UNIFORM);
    settle_block();

    // Random geometries, mostly whole frames, some cut short.
    while (random_items < RANDOM_GOAL) begin
      case ($urandom_range(0, 6))
        0:       cols_val = $urandom_range(0, 1);
        1:       cols_val = $urandom_range(13, 40);
        default: cols_val = $urandom_range(2, 12);
      endcase
      rows_val = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 6);
      wmask    = $urandom_range(1, 3);
      if ($urandom_range(0, 1) == 1) begin
        if (wmask[1]) write_frame_reg(stgrad_pkg::REG_FRAME_ROWS,
                                      rows_val[stgrad_pkg::CFG_DATA_W-1:0]);
        if (wmask[0]) write_frame_reg(stgrad_pkg::REG_FRAME_COLS,
                                      cols_val[stgrad_pkg::CFG_DATA_W-1:0]);
      end else begin
        if (wmask[0]) write_frame_reg(stgrad_pkg::REG_FRAME_COLS,
                                      cols_val[stgrad_pkg::CFG_DATA_W-1:0]);
        if (wmask[1]) write_frame_reg(stgrad_pkg::REG_FRAME_ROWS,
                                      rows_val[stgrad_pkg::CFG_DATA_W-1:0]);
      end
      frame_px = clamp_dim(frame_cols_q, LINE_DEPTH)
               * clamp_dim(frame_rows_q, stgrad_pkg::ROW_LIMIT);
      if ($urandom_range(0, 4) == 0) count = $urandom_range(1, frame_px - 1);
      else count = $urandom_range(1, 2) * frame_px;
      // Keep the total near the planned number of pixels.
      if (count > RANDOM_GOAL - random_items) count = RANDOM_GOAL - random_items;
      push_random(count, pix_style_e'($urandom_range(0, 2)));
      random_items += count;
      settle_block();
    end

    if (grad_expect_q.size() != 0) begin
      $error("%0d expected result words never arrived", grad_expect_q.size());
      fail_count++;
    end
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
